/* rtl/core/wab_pkg.sv */
// Shared definitions for the weighted average blend block.
// Holds the Q1.16 constants, the saturation helper, the back-end state type and
// the front-end status struct. Depends on nothing.
package wab_pkg;

  localparam int unsigned Q_W            = 17;
  localparam int unsigned Q_FRAC         = 16;
  localparam logic [16:0] Q_ONE          = 17'h10000;
  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIVIDE,
    BS_WALK
  } back_state_e;

  // Batch-end markers still travelling through the front pipeline.
  typedef struct packed {
    logic s1_last;
    logic s2_last;
  } front_stat_t;

  // Clamp a raw 17-bit code to the Q1.16 range 0..1.0.
  function automatic logic [16:0] sat_q(input logic [16:0] v);
    logic [16:0] r;
    r = (v > Q_ONE) ? Q_ONE : v;
    return r;
  endfunction

endpackage

/* rtl/core/wab_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module wab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/wab_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// The caller guarantees that the quotient fits in Q_W bits. Uses wab_pkg.
module wab_div
  import wab_pkg::*;
#(
  parameter int unsigned DividendW = 39,
  parameter int unsigned DivisorW  = 23
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [Q_W-1:0]       quot_o
);

  localparam int unsigned CntW = $clog2(Q_W + 1);

  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dvs_q;
  logic [Q_W-1:0]      dvd_q, dvd_d;
  logic [Q_W-1:0]      quo_q, quo_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                ge;

  always_comb begin
    trial  = {rem_q, dvd_q[Q_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = DivisorW'(dividend_i >> Q_W);
      dvd_d = dividend_i[Q_W-1:0];
      quo_d = '0;
      cnt_d = CntW'(Q_W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      dvd_d = {dvd_q[Q_W-2:0], 1'b0};
      quo_d = {quo_q[Q_W-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/core/wab_fifo.sv */
// Small register queue that carries batch descriptors from front to back.
// Depth comes from wab_pkg.
module wab_fifo
  import wab_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  logic [Width-1:0]                   data_i,
  input  logic                               pop_i,
  output logic                               valid_o,
  output logic [Width-1:0]                   data_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [Width-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

/* rtl/core/wab_front.sv */
// Front end: saturates and stores incoming points, forms the weight products
// and running sums, and closes a batch into a descriptor. Uses wab_pkg.
module wab_front
  import wab_pkg::*;
#(
  parameter int unsigned MaxPoints = MAX_POINTS_DEF,
  localparam int unsigned L     = $clog2(MaxPoints),
  localparam int unsigned IdxW  = (L > 0) ? L : 1,
  localparam int unsigned AddrW = IdxW + 1,
  localparam int unsigned DataW = 2 * Q_W + 1,
  localparam int unsigned CntW  = $clog2(MaxPoints + 1),
  localparam int unsigned SumW  = 33 + L,
  localparam int unsigned TotW  = 17 + L,
  localparam int unsigned DescW = 1 + CntW + SumW + TotW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [Q_W-1:0]       point_weight_i,
  input  logic                 has_weight_i,
  input  logic [Q_W-1:0]       influence_i,
  input  logic                 last_point_i,
  output logic                 ram_we_o,
  output logic [AddrW-1:0]     ram_waddr_o,
  output logic [DataW-1:0]     ram_wdata_o,
  output logic                 push_o,
  output logic [DescW-1:0]     desc_o,
  output front_stat_t          stat_o
);

  localparam int unsigned ProdW = 2 * Q_W;

  logic             s1_v_q, s1_last_q, s1_has_q;
  logic [Q_W-1:0]   s1_w_q, s1_infl_q;
  logic             s2_v_q, s2_last_q, s2_has_q;
  logic [Q_W-1:0]   s2_w_q, s2_infl_q;
  logic [ProdW-1:0] s2_prod_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [SumW-1:0]  wsum_q, wsum_d;
  logic [TotW-1:0]  itot_q, itot_d;
  logic             bank_q, bank_d;
  logic             stored;
  logic [CntW-1:0]  count_inc;
  logic [SumW-1:0]  wsum_add;
  logic [TotW-1:0]  itot_add;

  always_comb begin
    stored    = s2_v_q && (count_q < CntW'(MaxPoints));
    count_inc = count_q + CntW'(stored);
    wsum_add  = wsum_q + (stored ? SumW'(s2_prod_q) : '0);
    itot_add  = itot_q + ((stored && s2_has_q) ? TotW'(s2_infl_q) : '0);
    push_o    = s2_v_q && s2_last_q;
    desc_o    = {bank_q, count_inc, wsum_add, itot_add};
    count_d   = count_inc;
    wsum_d    = wsum_add;
    itot_d    = itot_add;
    bank_d    = bank_q;
    if (push_o) begin
      count_d = '0;
      wsum_d  = '0;
      itot_d  = '0;
      bank_d  = ~bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      count_q <= '0;
      wsum_q  <= '0;
      itot_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      s1_v_q  <= accept_i;
      s2_v_q  <= s1_v_q;
      count_q <= count_d;
      wsum_q  <= wsum_d;
      itot_q  <= itot_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_w_q    <= sat_q(point_weight_i);
      s1_infl_q <= sat_q(influence_i);
      s1_has_q  <= has_weight_i;
      s1_last_q <= last_point_i;
    end
    if (s1_v_q) begin
      s2_w_q    <= s1_w_q;
      s2_infl_q <= s1_infl_q;
      s2_has_q  <= s1_has_q;
      s2_last_q <= s1_last_q;
      s2_prod_q <= s1_has_q ? (ProdW'(s1_w_q) * ProdW'(s1_infl_q)) : '0;
    end
  end

  assign ram_we_o       = stored;
  assign ram_waddr_o    = {bank_q, count_q[IdxW-1:0]};
  assign ram_wdata_o    = {s2_has_q, s2_infl_q, s2_w_q};
  assign stat_o.s1_last = s1_v_q && s1_last_q;
  assign stat_o.s2_last = s2_v_q && s2_last_q;

endmodule

/* rtl/core/wab_back.sv */
// Back end: takes a batch descriptor, divides for the average, then walks the
// stored points and emits one blended result per cycle. Uses wab_pkg, wab_div.
module wab_back
  import wab_pkg::*;
#(
  parameter int unsigned MaxPoints = MAX_POINTS_DEF,
  localparam int unsigned L     = $clog2(MaxPoints),
  localparam int unsigned IdxW  = (L > 0) ? L : 1,
  localparam int unsigned AddrW = IdxW + 1,
  localparam int unsigned DataW = 2 * Q_W + 1,
  localparam int unsigned CntW  = $clog2(MaxPoints + 1),
  localparam int unsigned SumW  = 33 + L,
  localparam int unsigned TotW  = 17 + L,
  localparam int unsigned DescW = 1 + CntW + SumW + TotW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [DescW-1:0] desc_i,
  output logic             pop_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [DataW-1:0] ram_rdata_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output logic [Q_W-1:0]   new_weight_o,
  output logic             changed_o,
  output logic             last_result_o
);

  localparam int unsigned DiffW = Q_W + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam logic signed [ProdW-1:0] OneS = ProdW'(Q_ONE);

  back_state_e state_q, state_d;

  logic                    desc_bank;
  logic [CntW-1:0]         desc_n;
  logic [SumW-1:0]         desc_wsum;
  logic [TotW-1:0]         desc_itot;
  logic                    div_start, div_done;
  logic [Q_W-1:0]          div_quot;
  logic                    pop;
  logic                    rd_issue;
  logic                    at_end;
  logic [CntW-1:0]         k_q, k_d;
  logic [CntW-1:0]         n_q;
  logic                    bank_q;
  logic                    blend_q;
  logic [Q_W-1:0]          avg_q;
  logic                    rd_v_q, rd_last_q;
  logic                    mul_v_q, mul_last_q, mul_has_q;
  logic [Q_W-1:0]          mul_old_q;
  logic signed [ProdW-1:0] prod_q;
  logic [Q_W-1:0]          rd_w, rd_infl;
  logic                    rd_has;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] res_full;
  logic [Q_W-1:0]          clamped;
  logic                    out_v_q, out_ch_q, out_last_q;
  logic [Q_W-1:0]          out_nw_q;

  assign {desc_bank, desc_n, desc_wsum, desc_itot} = desc_i;

  wab_div #(
    .DividendW(SumW),
    .DivisorW (TotW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(desc_wsum),
    .divisor_i (desc_itot),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign at_end = (k_q == (n_q - CntW'(1)));

  always_comb begin
    state_d   = state_q;
    pop       = 1'b0;
    div_start = 1'b0;
    rd_issue  = 1'b0;
    k_d       = k_q;
    unique case (state_q)
      BS_IDLE: begin
        // A new batch starts only once the previous one has left the read and multiply stages.
        if (q_valid_i && !rd_v_q && !mul_v_q) begin
          pop = 1'b1;
          k_d = '0;
          if (desc_n != '0) begin
            if (desc_itot != '0) begin
              div_start = 1'b1;
              state_d   = BS_DIVIDE;
            end else begin
              state_d = BS_WALK;
            end
          end
        end
      end
      BS_DIVIDE: begin
        if (div_done) begin
          state_d = BS_WALK;
        end
      end
      BS_WALK: begin
        rd_issue = 1'b1;
        k_d      = k_q + CntW'(1);
        if (at_end) begin
          state_d = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_issue;
      mul_v_q <= rd_v_q;
      out_v_q <= mul_v_q;
    end
  end

  always_comb begin
    rd_w    = ram_rdata_i[Q_W-1:0];
    rd_infl = ram_rdata_i[2*Q_W-1:Q_W];
    rd_has  = ram_rdata_i[2*Q_W];
    diff    = $signed({1'b0, avg_q}) - $signed({1'b0, rd_w});
  end

  always_comb begin
    res_full = $signed(ProdW'(mul_old_q)) + (prod_q >>> Q_FRAC);
    if (res_full < 0) begin
      clamped = '0;
    end else if (res_full > OneS) begin
      clamped = Q_ONE;
    end else begin
      clamped = res_full[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (pop) begin
      bank_q  <= desc_bank;
      n_q     <= desc_n;
      blend_q <= (desc_itot != '0);
    end
    if (div_done) begin
      avg_q <= sat_q(div_quot);
    end
    rd_last_q <= rd_issue && at_end;
    if (rd_v_q) begin
      mul_old_q  <= rd_w;
      mul_has_q  <= rd_has;
      mul_last_q <= rd_last_q;
      prod_q     <= diff * $signed({1'b0, rd_infl});
    end
    if (mul_v_q) begin
      out_nw_q <= mul_has_q ? (blend_q ? clamped : mul_old_q) : '0;
    end
    // The flags are cleared between results so that they only show with one.
    out_ch_q   <= mul_v_q && mul_has_q && blend_q;
    out_last_q <= mul_v_q && mul_last_q;
  end

  assign pop_o          = pop;
  assign ram_raddr_o    = {bank_q, k_q[IdxW-1:0]};
  assign busy_o         = (state_q != BS_IDLE) || rd_v_q || mul_v_q;
  assign result_valid_o = out_v_q;
  assign new_weight_o   = out_nw_q;
  assign changed_o      = out_ch_q;
  assign last_result_o  = out_last_q;

endmodule

/* rtl/core/weighted_average_blend.sv */
// Top level of the weighted average blend block (average brush step).
// Uses wab_pkg and instantiates wab_front, wab_fifo, wab_back and wab_ram.
//
// The block takes one point per cycle while busy_o is low (a transaction is
// start_i high with busy_o low). Each point carries a Q1.16 weight, a flag
// that says the weight exists, an influence and a last-point mark; weights
// and influences above 1.0 are saturated. Points beyond MaxPoints are
// dropped, but their last-point mark still closes the batch. After the last
// point the block works out the average of the weights, weighted by
// influence, and then delivers one result per stored point, in load order,
// on consecutive cycles marked by result_valid_o. The receiver cannot stall:
// each result is present for exactly one cycle and must be taken then. A
// result is the old weight pulled toward the average by its influence and
// clamped to 0..1.0; points without a weight come out as zero, and if the
// influence sum is zero every weighted point passes through unchanged, in
// both cases with changed_o low. last_result_o marks the final result.
//
// Flow: an accepted point passes the front registers s1 and s2 before its
// batch is closed. The back end then runs the bit-serial divider (skipped when
// the influence sum is zero), after which results stream out one per cycle
// behind the memory read, multiply and clamp pipeline. The cost of a batch in
// the back end is set by the divider and the single read port of the point
// memory. The point memory has two banks, so the next batch loads while the
// current one is being emitted; busy_o is high while both banks are claimed
// by batches that have not finished emitting. No clearing pass is needed
// after reset.
module weighted_average_blend
  import wab_pkg::*;
#(
  parameter int unsigned MaxPoints = MAX_POINTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [Q_W-1:0] point_weight_i,
  input  logic           has_weight_i,
  input  logic [Q_W-1:0] influence_i,
  input  logic           last_point_i,
  output logic           result_valid_o,
  output logic [Q_W-1:0] new_weight_o,
  output logic           changed_o,
  output logic           last_result_o
);

  localparam int unsigned L     = $clog2(MaxPoints);
  localparam int unsigned IdxW  = (L > 0) ? L : 1;
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned DataW = 2 * Q_W + 1;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned SumW  = 33 + L;
  localparam int unsigned TotW  = 17 + L;
  localparam int unsigned DescW = 1 + CntW + SumW + TotW;
  localparam int unsigned QcW   = $clog2(QUEUE_DEPTH + 1);

  logic               accept;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [DataW-1:0]   ram_wdata, ram_rdata;
  logic               push, pop, q_valid;
  logic [DescW-1:0]   push_desc, head_desc;
  logic [QcW-1:0]     q_count;
  front_stat_t        fstat;
  logic               back_busy;
  logic [2:0]         claimed;

  // Every batch that is closed, or about to be closed, claims one memory
  // bank until its last result has been read out. The front end may fill
  // the remaining bank only while fewer than two banks are claimed.
  assign claimed = 3'(fstat.s1_last) + 3'(fstat.s2_last) + 3'(q_count) + 3'(back_busy);
  assign busy_o  = (claimed >= 3'd2);
  assign accept  = start_i && !busy_o;

  wab_front #(
    .MaxPoints(MaxPoints)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .point_weight_i(point_weight_i),
    .has_weight_i  (has_weight_i),
    .influence_i   (influence_i),
    .last_point_i  (last_point_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .push_o        (push),
    .desc_o        (push_desc),
    .stat_o        (fstat)
  );

  wab_ram #(
    .Width(DataW),
    .Depth(2 ** AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Batch descriptors wait here until the back end is free.
  wab_fifo #(
    .Width(DescW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_desc),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (head_desc),
    .count_o(q_count)
  );

  wab_back #(
    .MaxPoints(MaxPoints)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .desc_i        (head_desc),
    .pop_o         (pop),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .busy_o        (back_busy),
    .result_valid_o(result_valid_o),
    .new_weight_o  (new_weight_o),
    .changed_o     (changed_o),
    .last_result_o (last_result_o)
  );

`ifndef NO_ASSERTIONS
  // The two memory banks can never be claimed by more than two batches.
  a_claim_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claimed <= 3'd2)
    else $error("more batches in flight than memory banks");

  // A closing batch never finds the descriptor queue full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count != QcW'(QUEUE_DEPTH)))
    else $error("descriptor queue overflow");

  // The final-result mark and the changed flag only appear on a result.
  a_last_on_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_result_o || changed_o) |-> result_valid_o)
    else $error("result flag without a result");

  // A result never shows above 1.0.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (new_weight_o <= Q_ONE))
    else $error("result weight out of range");
`endif

endmodule

/* test/wab_blend_checker.sv */
// Checker for the weighted average blend block: watches the point and result
// channels, predicts every blended weight and compares it field by field.
// Depends on wab_pkg for the Q1.16 widths, the unit constant and the capacity.
module wab_blend_checker
  import wab_pkg::*;
#(
  parameter int unsigned MaxPoints = MAX_POINTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  logic [Q_W-1:0] point_weight_i,
  input  logic           has_weight_i,
  input  logic [Q_W-1:0] influence_i,
  input  logic           last_point_i,
  input  logic           result_valid_i,
  input  logic [Q_W-1:0] new_weight_i,
  input  logic           changed_i,
  input  logic           last_result_i,
  output int unsigned    mismatch_count_o,
  output int unsigned    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNIT = 65536;

  typedef struct packed {
    logic [Q_W-1:0] blended_w;
    logic           changed;
    logic           last_result;
  } blend_result_t;

  blend_result_t  blended_queue[$];
  logic [Q_W-1:0] batch_weight[MaxPoints];
  logic [Q_W-1:0] batch_influence[MaxPoints];
  logic           batch_present[MaxPoints];
  longint unsigned product_sum;
  longint unsigned infl_total;
  int unsigned    points_loaded;
  int unsigned    mismatches;
  int unsigned    results_seen;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: result %0d: %s", $time, results_seen, msg);
  endtask

  function automatic logic [Q_W-1:0] unit_clamp(input longint unsigned v);
    return (v > longint'(UNIT)) ? Q_ONE : v[Q_W-1:0];
  endfunction

  // Pull the old weight toward the average; the arithmetic shift floors.
  function automatic logic [Q_W-1:0] pull_toward(input logic [Q_W-1:0] old_w,
                                                  input logic [Q_W-1:0] avg,
                                                  input logic [Q_W-1:0] infl);
    longint diff;
    longint moved;
    diff  = longint'(avg) - longint'(old_w);
    moved = longint'(old_w) + ((diff * longint'(infl)) >>> Q_FRAC);
    if (moved < 0) moved = 0;
    if (moved > UNIT) moved = UNIT;
    return moved[Q_W-1:0];
  endfunction

  task automatic close_batch();
    logic [Q_W-1:0] avg;
    logic           blending;
    blend_result_t  r;
    blending = (infl_total != 0);
    avg = blending ? unit_clamp(product_sum / infl_total) : '0;
    for (int unsigned k = 0; k < points_loaded; k++) begin
      r = '0;
      if (batch_present[k]) begin
        r.blended_w = blending ? pull_toward(batch_weight[k], avg, batch_influence[k])
                               : batch_weight[k];
        r.changed   = blending;
      end
      r.last_result = (k + 1 == points_loaded);
      blended_queue.push_back(r);
    end
    product_sum   = 0;
    infl_total    = 0;
    points_loaded = 0;
  endtask

  always @(posedge clk_i) begin
    blend_result_t want;
    logic [Q_W-1:0] w;
    logic [Q_W-1:0] infl;
    if (!rst_ni) begin
      blended_queue.delete();
      product_sum   = 0;
      infl_total    = 0;
      points_loaded = 0;
    end else begin
      if (result_valid_i) begin
        if (blended_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result, weight %0d", new_weight_i));
        end else begin
          want = blended_queue.pop_front();
          if (new_weight_i !== want.blended_w)
            report_mismatch($sformatf("weight %0d, want %0d",
                                      new_weight_i, want.blended_w));
          if (changed_i !== want.changed)
            report_mismatch($sformatf("changed %0b, want %0b", changed_i, want.changed));
          if (last_result_i !== want.last_result)
            report_mismatch($sformatf("last_result %0b, want %0b",
                                      last_result_i, want.last_result));
        end
        results_seen++;
      end
      if (start_i && !busy_i) begin
        if (points_loaded < MaxPoints) begin
          w    = unit_clamp(longint'(point_weight_i));
          infl = unit_clamp(longint'(influence_i));
          batch_weight[points_loaded]    = w;
          batch_influence[points_loaded] = infl;
          batch_present[points_loaded]   = has_weight_i;
          if (has_weight_i) begin
            product_sum += longint'(w) * longint'(infl);
            infl_total  += longint'(infl);
          end
          points_loaded++;
        end
        if (last_point_i) close_batch();
      end
    end
    outstanding_o    <= blended_queue.size();
    mismatch_count_o <= mismatches;
  end

endmodule

/* test/tb_weighted_average_blend.sv */
// Testbench top for the weighted average blend block: clock, reset, stimulus
// and the final verdict. Depends on wab_pkg, weighted_average_blend and the
// wab_blend_checker module, which does all prediction and comparison.
module tb_weighted_average_blend
  import wab_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Number of random points to push after the directed batches.
  localparam int unsigned RANDOM_POINTS = 420;
  // The last stretch of the random part runs with the sender never idling.
  localparam int unsigned STEADY_TAIL = 60;
  // Wait well beyond the back end and front pipeline latency after the last
  // result to catch stray results.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic           clk_i          = 1'b0;
  logic           rst_ni         = 1'b0;
  logic           start_i        = 1'b0;
  logic [Q_W-1:0] point_weight_i = '0;
  logic           has_weight_i   = 1'b0;
  logic [Q_W-1:0] influence_i    = '0;
  logic           last_point_i   = 1'b0;
  logic           busy_o;
  logic           result_valid_o;
  logic [Q_W-1:0] new_weight_o;
  logic           changed_o;
  logic           last_result_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count  = 0;
  int unsigned random_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weighted_average_blend u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .point_weight_i (point_weight_i),
    .has_weight_i   (has_weight_i),
    .influence_i    (influence_i),
    .last_point_i   (last_point_i),
    .result_valid_o (result_valid_o),
    .new_weight_o   (new_weight_o),
    .changed_o      (changed_o),
    .last_result_o  (last_result_o)
  );

  wab_blend_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .point_weight_i   (point_weight_i),
    .has_weight_i     (has_weight_i),
    .influence_i      (influence_i),
    .last_point_i     (last_point_i),
    .result_valid_i   (result_valid_o),
    .new_weight_i     (new_weight_o),
    .changed_i        (changed_o),
    .last_result_i    (last_result_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Present one point and hold it until a transaction takes place, that is
  // until an edge at which busy_o is low. Called at a rising edge; returns at
  // the accepting edge so that the next point can follow back to back.
  task automatic send_point(input logic [Q_W-1:0] w, input logic has,
                            input logic [Q_W-1:0] infl, input logic last);
    start_i        <= 1'b1;
    point_weight_i <= w;
    has_weight_i   <= has;
    influence_i    <= infl;
    last_point_i   <= last;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold the sender off until every predicted result has arrived. The first
  // edge lets the checker's count catch up with the transaction just taken.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Mostly legal Q1.16 values, with the end points and codes above 1.0
  // (which the block saturates) mixed in so that every bit toggles.
  function automatic logic [Q_W-1:0] random_q();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_ONE;
      2:       return Q_W'($urandom_range(32'h10001, 32'h1FFFF));
      default: return Q_W'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  // One brush sample of random points, closed by a last-point mark. A few
  // samples have no influence at all or no weights at all, so that the
  // pass-through paths are hit with random content too.
  task automatic random_batch(input int unsigned len, input int unsigned idle_pct);
    int unsigned    flavor;
    logic [Q_W-1:0] w;
    logic [Q_W-1:0] infl;
    logic           has;
    flavor = $urandom_range(0, 11);
    for (int unsigned i = 0; i < len; i++) begin
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 18));
      w    = random_q();
      infl = random_q();
      has  = ($urandom_range(0, 4) != 0);
      if (flavor == 0) infl = '0;
      if (flavor == 1) has = 1'b0;
      send_point(w, has, infl, i == len - 1);
      // Points past capacity are dropped, so only count the ones that load
      // or that close the batch.
      if (i < MAX_POINTS_DEF || i == len - 1) random_count++;
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned idle_pct;
    logic        steady;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A single full weight at full influence stays at 1.0.
    send_point(Q_ONE, 1'b1, Q_ONE, 1'b1);

    // Weights 0 and 1.0 meet at one half from both sides (the downward step
    // exercises the floor of a negative product); a point without a weight
    // comes out as zero and unchanged.
    send_point('0, 1'b1, Q_ONE, 1'b0);
    send_point(Q_ONE, 1'b1, Q_ONE, 1'b0);
    send_point(17'd12345, 1'b0, 17'd40000, 1'b1);

    // Zero influence sum: every weighted point passes through unchanged.
    send_point(17'd1000, 1'b1, '0, 1'b0);
    send_point(Q_ONE, 1'b1, '0, 1'b0);
    send_point('0, 1'b1, '0, 1'b1);

    // No point carries a weight, so the influence sum is zero as well.
    send_point(17'd500, 1'b0, Q_ONE, 1'b0);
    send_point(Q_ONE, 1'b0, 17'd100, 1'b1);

    // Codes above 1.0 are saturated on load; small influences give steps
    // that round down toward minus infinity.
    send_point(17'h1FFFF, 1'b1, 17'h1FFFF, 1'b0);
    send_point(17'h10001, 1'b1, 17'h10001, 1'b0);
    send_point('0, 1'b1, 17'd1, 1'b0);
    send_point(17'd3, 1'b1, 17'd65535, 1'b1);

    // Smallest nonzero values against near-full ones.
    send_point(17'd1, 1'b1, 17'd1, 1'b0);
    send_point(17'd65535, 1'b1, 17'd65535, 1'b1);

    // Alternating bit patterns in both fields.
    send_point(17'h15555, 1'b1, 17'h0AAAA, 1'b0);
    send_point(17'h0AAAA, 1'b1, 17'h15555, 1'b1);

    // Let the block empty out completely before the random part.
    drain_results();

    // Beyond capacity: the extra points are dropped and the mark on the
    // last, dropped point still closes the batch.
    random_batch(MAX_POINTS_DEF + 3, 30);
    drain_results();
    // Exactly full, sent back to back.
    random_batch(MAX_POINTS_DEF, 0);

    while (random_count < RANDOM_POINTS) begin
      steady = (random_count + STEADY_TAIL >= RANDOM_POINTS);
      if (!steady && $urandom_range(0, 29) == 0) begin
        len = $urandom_range(MAX_POINTS_DEF - 4, MAX_POINTS_DEF + 6);
      end else begin
        len = $urandom_range(1, 12);
      end
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (steady) idle_pct = 0;
      // Gaps between samples as well, so that the sender also goes quiet
      // while the divider or the emit walk is running.
      if (idle_pct != 0 && $urandom_range(0, 2) == 0) pause($urandom_range(1, 18));
      random_batch(len, idle_pct);
      if (!steady && $urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
